@@ hdl/gbns_pkg.sv @@
package gbns_pkg;

  localparam int SEQ_W  = 16;
  localparam int DATA_W = 64;
  // Sized for the largest window the core supports (16 packets)
  localparam int CNT_W  = 5;
  localparam int PTR_W  = 4;

  localparam logic [1:0] MODE_SEND    = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    CMD_NULL,
    CMD_SEND,
    CMD_ACK,
    CMD_RETX
  } cmd_kind_t;

  // One classified item handed from front to back.
  // seq  : send seq / old base for ack / base for retransmit
  // seq2 : new base after ack
  // flag : send into empty window / packets remain after ack
  typedef struct packed {
    cmd_kind_t           kind;
    logic [SEQ_W-1:0]    seq;
    logic [SEQ_W-1:0]    seq2;
    logic                flag;
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    cnt;
    logic [PTR_W-1:0]    ptr;
  } cmd_t;

endpackage

@@ hdl/go_back_n_sender_core.sv @@
// Go-Back-N sender core. Each input transaction is a send (tuser 0), an
// acknowledgement (tuser 1) or a timer expiry (tuser 2); it produces one or more
// result transactions, the final one marked by out_tlast. Sends and dropped
// items give one result, a good cumulative acknowledgement one or two (timer
// stop, then timer restart on the new oldest packet), and a timeout with N
// packets outstanding gives N retransmissions. The front end classifies and
// updates window state and passes a command through a two-entry queue; the
// back end emits one result per cycle while the receiver is ready, through a
// registered output. After a timeout the input hold-off is only released once
// the last retransmission has been issued. While a retransmission is queued
// or running the input is held off, since the back end is reading the packet
// buffer; the buffer (WINDOW words of 64 bits) is a ring addressed from the
// oldest unacknowledged packet. WINDOW may be set from 1 to 16.
module go_back_n_sender_core
  import gbns_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // mode
  input  logic [87:0]  in_tdata,   // payload[63:0], ack_number[79:64], ack_check_ok[80]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  output logic         out_tuser,  // packet_valid
  output logic [103:0] out_tdata   // packet_seq[15:0], packet_data[79:16], accepted[80],
                                   // timer_start[81], timer_stop[82], timer_seq[98:83]
);

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic              f_cmd_valid, f_cmd_ready;
  cmd_t              f_cmd;
  logic              b_cmd_valid, b_cmd_ready;
  cmd_t              b_cmd;
  logic              rtx_done;
  logic [PW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              pv, acc, tstart, tstop;
  logic [SEQ_W-1:0]  pseq, tseq;
  logic [DATA_W-1:0] pdata;

  // Front end: window bookkeeping and packet buffer
  gbns_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .mode         (in_tuser),
    .payload      (in_tdata[63:0]),
    .ack_number   (in_tdata[79:64]),
    .ack_check_ok (in_tdata[80]),
    .cmd_valid    (f_cmd_valid),
    .cmd_ready    (f_cmd_ready),
    .cmd          (f_cmd),
    .rtx_done     (rtx_done),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  gbns_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_cmd_valid),
    .wr_ready (f_cmd_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_cmd_valid),
    .rd_ready (b_cmd_ready),
    .rd_data  (b_cmd)
  );

  // Back end: expands each command into result transactions
  gbns_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (b_cmd_valid),
    .cmd_ready    (b_cmd_ready),
    .cmd          (b_cmd),
    .rtx_done     (rtx_done),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .packet_valid (pv),
    .packet_seq   (pseq),
    .packet_data  (pdata),
    .accepted     (acc),
    .timer_start  (tstart),
    .timer_stop   (tstop),
    .timer_seq    (tseq),
    .last         (out_tlast)
  );

  assign out_tuser = pv;
  assign out_tdata = {5'd0, tseq, tstop, tstart, acc, pdata, pseq};

endmodule

@@ hdl/gbns_front.sv @@
module gbns_front
  import gbns_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic [DATA_W-1:0]                    payload,
  input  logic [SEQ_W-1:0]                     ack_number,
  input  logic                                 ack_check_ok,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output cmd_t                                 cmd,
  input  logic                                 rtx_done,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0]                    rd_data
);

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] WIN_C  = CW'(WINDOW);
  localparam logic [SW-1:0] WIN_SW = SW'(WINDOW);

  logic [SEQ_W-1:0]  base_r, base_nxt;
  logic [SEQ_W-1:0]  nseq_r, nseq_nxt;
  logic [CW-1:0]     outs_r, outs_nxt;
  logic              full_r, full_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic              rtx_pend_r, rtx_pend_nxt;
  logic [DATA_W-1:0] store_r [WINDOW];

  logic              accept;
  logic              we;
  logic [SW-1:0]     wr_sum;
  logic [PW-1:0]     wr_idx;
  logic [SEQ_W-1:0]  ack_off;
  logic              ack_hit;
  logic [CW-1:0]     acked;
  logic [SW-1:0]     hd_sum;

  // Hold off new items while a retransmission still reads the buffer
  assign in_ready = cmd_ready && !rtx_pend_r;
  assign accept   = in_valid && in_ready;
  assign rd_data  = store_r[rd_addr];

  assign wr_sum = SW'(head_r) + SW'(outs_r);
  assign wr_idx = (wr_sum >= WIN_SW) ? PW'(wr_sum - WIN_SW) : PW'(wr_sum);

  assign ack_off = ack_number - base_r;
  assign ack_hit = (outs_r != '0) && ack_check_ok && (ack_off < SEQ_W'(outs_r));
  assign acked   = CW'(ack_off) + CW'(1);
  assign hd_sum  = SW'(head_r) + SW'(acked);

  always_comb begin
    base_nxt     = base_r;
    nseq_nxt     = nseq_r;
    outs_nxt     = outs_r;
    full_nxt     = full_r;
    head_nxt     = head_r;
    rtx_pend_nxt = rtx_pend_r && !rtx_done;
    we           = 1'b0;
    cmd_valid    = accept;
    cmd          = '0;
    cmd.kind     = CMD_NULL;
    if (accept) begin
      if (mode == MODE_SEND) begin
        if (!full_r) begin
          we        = 1'b1;
          outs_nxt  = outs_r + CW'(1);
          nseq_nxt  = nseq_r + SEQ_W'(1);
          full_nxt  = (outs_r + CW'(1)) == WIN_C;
          cmd.kind  = CMD_SEND;
          cmd.seq   = nseq_r;
          cmd.flag  = (outs_r == '0);
          cmd.data  = payload;
        end
      end else if (mode == MODE_ACK) begin
        if (ack_hit) begin
          base_nxt  = base_r + SEQ_W'(acked);
          outs_nxt  = outs_r - acked;
          full_nxt  = 1'b0;
          head_nxt  = (hd_sum >= WIN_SW) ? PW'(hd_sum - WIN_SW) : PW'(hd_sum);
          cmd.kind  = CMD_ACK;
          cmd.seq   = base_r;
          cmd.seq2  = base_r + SEQ_W'(acked);
          cmd.flag  = (outs_r != acked);
        end
      end else if (mode == MODE_TIMEOUT) begin
        if (outs_r != '0) begin
          rtx_pend_nxt = 1'b1;
          cmd.kind     = CMD_RETX;
          cmd.seq      = base_r;
          cmd.cnt      = CNT_W'(outs_r);
          cmd.ptr      = PTR_W'(head_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      nseq_r     <= '0;
      outs_r     <= '0;
      full_r     <= 1'b0;
      head_r     <= '0;
      rtx_pend_r <= 1'b0;
    end else begin
      base_r     <= base_nxt;
      nseq_r     <= nseq_nxt;
      outs_r     <= outs_nxt;
      full_r     <= full_nxt;
      head_r     <= head_nxt;
      rtx_pend_r <= rtx_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[wr_idx] <= payload;
    end
  end

endmodule

@@ hdl/gbns_cmd_fifo.sv @@
module gbns_cmd_fifo
  import gbns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/gbns_back.sv @@
module gbns_back
  import gbns_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  cmd_t                                 cmd,
  output logic                                 rtx_done,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr,
  input  logic [DATA_W-1:0]                    rd_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 packet_valid,
  output logic [SEQ_W-1:0]                     packet_seq,
  output logic [DATA_W-1:0]                    packet_data,
  output logic                                 accepted,
  output logic                                 timer_start,
  output logic                                 timer_stop,
  output logic [SEQ_W-1:0]                     timer_seq,
  output logic                                 last
);

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] WIN_SW = SW'(WINDOW);

  typedef struct packed {
    logic              pv;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
    logic              acc;
    logic              tstart;
    logic              tstop;
    logic [SEQ_W-1:0]  tseq;
    logic              last;
  } res_t;

  logic          out_valid_r, out_valid_nxt;
  res_t          res_r;
  logic          active_r, active_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  cmd_t          src;
  logic [CW-1:0] src_idx;
  logic          can_load, load;
  logic [SW-1:0] rd_sum;
  res_t          res;

  assign src       = active_r ? cur_r : cmd;
  assign src_idx   = active_r ? idx_r : '0;
  assign can_load  = !out_valid_r || out_ready;
  assign load      = can_load && (active_r || cmd_valid);
  assign cmd_ready = can_load && !active_r;

  assign rd_sum  = SW'(src.ptr[PW-1:0]) + SW'(src_idx);
  assign rd_addr = (rd_sum >= WIN_SW) ? PW'(rd_sum - WIN_SW) : PW'(rd_sum);

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    unique case (src.kind)
      CMD_NULL: begin
        res.last = 1'b1;
      end
      CMD_SEND: begin
        res.pv     = 1'b1;
        res.seq    = src.seq;
        res.data   = src.data;
        res.acc    = 1'b1;
        res.tstart = src.flag;
        res.tseq   = src.flag ? src.seq : '0;
      end
      CMD_ACK: begin
        if (src_idx == '0) begin
          res.tstop = 1'b1;
          res.tseq  = src.seq;
          res.last  = !src.flag;
        end else begin
          res.tstart = 1'b1;
          res.tseq   = src.seq2;
        end
      end
      CMD_RETX: begin
        res.pv   = 1'b1;
        res.seq  = src.seq + SEQ_W'(src_idx);
        res.data = rd_data;
        if (src_idx == '0) begin
          res.tstart = 1'b1;
          res.tstop  = 1'b1;
          res.tseq   = src.seq;
        end
        res.last = (src_idx + CW'(1)) == src.cnt[CW-1:0];
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    active_nxt    = active_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (can_load) begin
      out_valid_nxt = load;
    end
    if (load) begin
      active_nxt = !res.last;
      cur_nxt    = src;
      idx_nxt    = src_idx + CW'(1);
    end
  end

  assign rtx_done = load && res.last && (src.kind == CMD_RETX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign packet_valid = res_r.pv;
  assign packet_seq   = res_r.seq;
  assign packet_data  = res_r.data;
  assign accepted     = res_r.acc;
  assign timer_start  = res_r.tstart;
  assign timer_stop   = res_r.tstop;
  assign timer_seq    = res_r.tseq;
  assign last         = res_r.last;

endmodule

@@ tb/go_back_n_sender_core_tb.sv @@
module go_back_n_sender_core_tb;
  import gbns_pkg::*;

  localparam int WINDOW       = 4;
  localparam int RAND_PER_PH  = 97;     // random items in each idling phase
  localparam int HOLD_CYCLES  = 60;     // long receiver hold-off, block must back up
  localparam int DRAIN_CYCLES = 20;     // quiet time after the last expected result
  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, must be dropped

  // One input transaction as the block sees it
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] payload;
    logic [15:0] ack;
    logic        ok;
  } gbn_item_t;

  // One result transaction, field for field
  typedef struct packed {
    logic        pv;
    logic [15:0] seq;
    logic [63:0] data;
    logic        acc;
    logic        tstart;
    logic        tstop;
    logic [15:0] tseq;
    logic        last;
  } gbn_result_t;

  // Directed row: the expected result is typed in only where lit is set
  typedef struct packed {
    gbn_item_t   item;
    logic        lit;
    gbn_result_t res;
  } dir_row_t;

  localparam gbn_result_t NULL_RES = '{pv: 1'b0, seq: 16'd0, data: 64'd0, acc: 1'b0,
                                       tstart: 1'b0, tstop: 1'b0, tseq: 16'd0,
                                       last: 1'b1};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = 2'd0;
  logic [87:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         out_tlast;
  logic         out_tuser;
  logic [103:0] out_tdata;

  go_back_n_sender_core #(.WINDOW(WINDOW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Sender-side window mirror: base, next sequence number, buffered payloads
  logic [15:0] win_base;
  logic [15:0] next_seq_no;
  int          win_count;
  logic [63:0] unacked_words [WINDOW];

  gbn_result_t awaited_results[$];   // expected result transactions, oldest first
  gbn_result_t step_results[$];      // results of the item just accepted

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stall_start = 1'b0;          // raised by stimulus, serviced by receiver
  logic stall_done = 1'b0;
  int hold_cnt = 0;

  int n_items = 0, n_sent = 0, n_refused = 0, n_acked = 0;
  int n_timeouts = 0, n_retx = 0, n_dropped = 0, n_checked = 0;

  function automatic gbn_result_t mk_res(logic pv, logic [15:0] seq, logic [63:0] data,
                                         logic acc, logic ts, logic tp,
                                         logic [15:0] tseq, logic last);
    gbn_result_t r;
    r = '{pv: pv, seq: seq, data: data, acc: acc, tstart: ts, tstop: tp, tseq: tseq,
          last: last};
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] mode, logic [63:0] payload,
                                      logic [15:0] ack, logic ok, logic lit,
                                      gbn_result_t res);
    dir_row_t d;
    d.item = '{mode: mode, payload: payload, ack: ack, ok: ok};
    d.lit  = lit;
    d.res  = res;
    return d;
  endfunction

  // Window update for one accepted transaction; fills step_results
  task advance_window(input gbn_item_t it);
    gbn_result_t r;
    logic [15:0] ack_off;
    int acked;
    step_results.delete();
    r = NULL_RES;
    n_items++;
    case (it.mode)
      MODE_SEND: begin
        if (win_count < WINDOW) begin
          unacked_words[win_count] = it.payload;
          r.pv   = 1'b1;
          r.seq  = next_seq_no;
          r.data = it.payload;
          r.acc  = 1'b1;
          if (win_count == 0) begin
            r.tstart = 1'b1;
            r.tseq   = next_seq_no;
          end
          win_count++;
          next_seq_no++;
          n_sent++;
        end else begin
          n_refused++;
        end
        step_results.push_back(r);
      end
      MODE_ACK: begin
        ack_off = it.ack - win_base;
        if (win_count != 0 && it.ok && int'(ack_off) < win_count) begin
          acked = int'(ack_off) + 1;
          for (int i = 0; i < win_count - acked; i++)
            unacked_words[i] = unacked_words[i + acked];
          r.tstop = 1'b1;
          r.tseq  = win_base;
          r.last  = (win_count == acked);
          step_results.push_back(r);
          win_base  = win_base + 16'(acked);
          win_count = win_count - acked;
          if (win_count != 0)
            step_results.push_back(mk_res(1'b0, 16'd0, 64'd0, 1'b0, 1'b1, 1'b0,
                                          win_base, 1'b1));
          n_acked++;
        end else begin
          n_dropped++;
          step_results.push_back(r);
        end
      end
      MODE_TIMEOUT: begin
        if (win_count != 0) begin
          for (int i = 0; i < win_count; i++)
            step_results.push_back(mk_res(1'b1, win_base + 16'(i), unacked_words[i], 1'b0,
                                          i == 0, i == 0, (i == 0) ? win_base : 16'd0,
                                          i == win_count - 1));
          n_timeouts++;
          n_retx += win_count;
        end else begin
          n_dropped++;
          step_results.push_back(r);
        end
      end
      default: begin
        n_dropped++;
        step_results.push_back(r);
      end
    endcase
  endtask

  // Random item, weighted towards acks that actually land inside the window
  function automatic gbn_item_t pick_item();
    gbn_item_t it;
    int r;
    int sub;
    it.payload = {$urandom, $urandom};
    it.ack     = 16'($urandom);
    it.ok      = 1'($urandom);
    r   = $urandom_range(99);
    sub = $urandom_range(99);
    if (r < 45) begin
      it.mode = MODE_SEND;
    end else if (r < 80) begin
      it.mode = MODE_ACK;
      if (win_count != 0 && sub < 80) begin
        it.ack = win_base + 16'($urandom_range(win_count - 1));
        it.ok  = (sub < 70);
      end else if (sub < 90) begin
        it.ack = next_seq_no + 16'($urandom_range(3));
        it.ok  = 1'b1;
      end
    end else if (r < 96) begin
      it.mode = MODE_TIMEOUT;
    end else begin
      it.mode = MODE_SPARE;
    end
    return it;
  endfunction

  // Offer one transaction, with sender gaps; returns at the accepting edge
  task automatic offer_item(input gbn_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {7'd0, it.ok, it.ack, it.payload};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  task check_result();
    gbn_result_t got;
    gbn_result_t want;
    got = '{pv: out_tuser, seq: out_tdata[15:0], data: out_tdata[79:16],
            acc: out_tdata[80], tstart: out_tdata[81], tstop: out_tdata[82],
            tseq: out_tdata[98:83], last: out_tlast};
    n_checked++;
    if (awaited_results.size() == 0) begin
      $error("result transaction with nothing expected (seq %0h, tseq %0h)",
             got.seq, got.tseq);
      err_count++;
    end else begin
      want = awaited_results.pop_front();
      cmp_field("packet_valid", want.pv, got.pv);
      cmp_field("packet_seq", want.seq, got.seq);
      cmp_field("packet_data", want.data, got.data);
      cmp_field("accepted", want.acc, got.acc);
      cmp_field("timer_start", want.tstart, got.tstart);
      cmp_field("timer_stop", want.tstop, got.tstop);
      cmp_field("timer_seq", want.tseq, got.tseq);
      cmp_field("last", want.last, got.last);
    end
  endtask

  // Receiver: checks each accepted result, then picks next ready. A requested
  // hold-off is counted here so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_result();
      if (stall_start && !stall_done) begin
        stall_done <= 1'b1;
        hold_cnt   <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus: directed table, then three random phases with different idling
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    gbn_item_t it;

    win_base    = 16'd0;
    next_seq_no = 16'd0;
    win_count   = 0;
    foreach (unacked_words[i])
      unacked_words[i] = 64'd0;

    // from reset: empty window, then fill it, poke every drop path, then drain
    dir_rows.push_back(mk_row(MODE_TIMEOUT, 64'd0, 16'd0, 1'b0, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd0, 1'b1, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_SPARE, '1, '1, 1'b1, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_SEND, '1, 16'd0, 1'b0, 1'b1,
                              mk_res(1'b1, 16'd0, '1, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1)));
    dir_rows.push_back(mk_row(MODE_SEND, 64'd0, '1, 1'b1, 1'b1,
                              mk_res(1'b1, 16'd1, 64'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1)));
    dir_rows.push_back(mk_row(MODE_SEND, 64'ha5a5_a5a5_a5a5_a5a5, 16'd0, 1'b0, 1'b0,
                              NULL_RES));
    dir_rows.push_back(mk_row(MODE_SEND, 64'h5a5a_5a5a_5a5a_5a5a, 16'd0, 1'b0, 1'b0,
                              NULL_RES));
    // window full: refused
    dir_rows.push_back(mk_row(MODE_SEND, 64'h1234, 16'd0, 1'b0, 1'b1, NULL_RES));
    // bad checksum, ack at next seq, ack behind base: all dropped
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd1, 1'b0, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd4, 1'b1, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'hffff, 1'b1, 1'b1, NULL_RES));
    // full retransmission, partial ack with restart, refill, retransmit again
    dir_rows.push_back(mk_row(MODE_TIMEOUT, 64'd0, 16'd0, 1'b0, 1'b0, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd0, 1'b1, 1'b0, NULL_RES));
    dir_rows.push_back(mk_row(MODE_SEND, 64'h0123_4567_89ab_cdef, 16'd0, 1'b0, 1'b0,
                              NULL_RES));
    dir_rows.push_back(mk_row(MODE_TIMEOUT, 64'd0, 16'd0, 1'b0, 1'b0, NULL_RES));
    // ack of the newest packet empties the window
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd4, 1'b1, 1'b0, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd4, 1'b1, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_TIMEOUT, 64'd0, 16'd0, 1'b0, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_SEND, 64'h8000_0000_0000_0001, 16'd0, 1'b0, 1'b0,
                              NULL_RES));
    dir_rows.push_back(mk_row(MODE_SPARE, 64'd0, 16'd5, 1'b1, 1'b1, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd5, 1'b0, 1'b1, NULL_RES));
    // single-packet timeout, then its ack
    dir_rows.push_back(mk_row(MODE_TIMEOUT, 64'd0, 16'd0, 1'b0, 1'b0, NULL_RES));
    dir_rows.push_back(mk_row(MODE_ACK, 64'd0, 16'd5, 1'b1, 1'b0, NULL_RES));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 50;
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      offer_item(row.item);
      advance_window(row.item);
      if (row.lit)
        awaited_results.push_back(row.res);
      else
        foreach (step_results[j])
          awaited_results.push_back(step_results[j]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_start   = 1'b1;   // receiver holds off while items keep coming
        end
      endcase
      repeat (RAND_PER_PH) begin
        it = pick_item();
        offer_item(it);
        advance_window(it);
        foreach (step_results[j])
          awaited_results.push_back(step_results[j]);
      end
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d sends taken, %0d refused, %0d acks honoured,",
             n_items, n_sent, n_refused, n_acked);
    $display("%0d timeouts resending %0d packets, %0d items dropped, %0d results checked",
             n_timeouts, n_retx, n_dropped, n_checked);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timed out with %0d results outstanding", awaited_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
